@@ rtl/core/rbf_pkg.sv @@
// ----------------------------------------------------------------------------
// rbf_pkg
// Shared types, constants and helpers for the RGB 3x3 box filter.
// ----------------------------------------------------------------------------
package rbf_pkg;

  // Line store depth and the column counter width that follows from it
  localparam int unsigned MaxWidth = 1024;
  localparam int unsigned ColW     = $clog2(MaxWidth);

  // Configuration register widths and reset values
  localparam int unsigned CfgWidthW  = 11;
  localparam int unsigned CfgHeightW = 12;
  localparam int unsigned CfgDataW   = 12;
  localparam int unsigned CfgIdxW    = 2;

  localparam logic [CfgWidthW-1:0]  WidthReset  = CfgWidthW'(MaxWidth);
  localparam logic [CfgHeightW-1:0] HeightReset = CfgHeightW'(3);

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegImageWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 2'd1;

  // One RGB pixel
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pix_t;

  // Position info of an accepted pixel
  typedef struct packed {
    logic [ColW-1:0] col;
    logic            emit;
    logic            last;
  } pos_t;

  // floor(x/9) for an 8-bit x: x*57 >> 9 is exact over 0..255
  function automatic logic [4:0] div9(input logic [7:0] x);
    logic [13:0] prod;
    prod = 14'(x) * 14'd57;
    return prod[13:9];
  endfunction

endpackage

@@ rtl/core/rbf_line_store.sv @@
// ----------------------------------------------------------------------------
// rbf_line_store
// One row of pixels: single write port, single registered read port.
// ----------------------------------------------------------------------------
module rbf_line_store
  import rbf_pkg::*;
(
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [ColW-1:0] waddr_i,
  input  pix_t            wdata_i,
  input  logic            re_i,
  input  logic [ColW-1:0] raddr_i,
  output pix_t            rdata_o
);

  pix_t mem [MaxWidth];
  pix_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/rbf_ctrl.sv @@
// ----------------------------------------------------------------------------
// rbf_ctrl
// Configuration registers and raster position counters.
// ----------------------------------------------------------------------------
module rbf_ctrl
  import rbf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                accept_i,
  output pos_t                pos_o
);

  logic [CfgWidthW-1:0]  width_q;
  logic [CfgHeightW-1:0] height_q;
  logic [ColW-1:0]       col_q, col_d;
  logic [CfgHeightW-1:0] row_q, row_d;
  logic [CfgWidthW-1:0]  eff_w;
  logic [CfgHeightW-1:0] eff_h;
  logic                  col_end, row_end;
  logic                  cfg_hit;

  // Effective frame size: width saturated to [3, MaxWidth], height at least 3
  always_comb begin
    eff_w = width_q;
    if (width_q < CfgWidthW'(3)) begin
      eff_w = CfgWidthW'(3);
    end else if (width_q > CfgWidthW'(MaxWidth)) begin
      eff_w = CfgWidthW'(MaxWidth);
    end
    eff_h = (height_q < CfgHeightW'(3)) ? CfgHeightW'(3) : height_q;
  end

  assign col_end = (CfgWidthW'(col_q) == eff_w - CfgWidthW'(1));
  assign row_end = (row_q == eff_h - CfgHeightW'(1));
  assign cfg_hit = cfg_we_i &&
                   (cfg_idx_i == RegImageWidth || cfg_idx_i == RegImageHeight);

  // Position of the pixel being accepted
  assign pos_o.col  = col_q;
  assign pos_o.emit = (row_q >= CfgHeightW'(2)) && (col_q >= ColW'(2));
  assign pos_o.last = row_end && col_end;

  // Next position
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (accept_i) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + CfgHeightW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cfg_we_i && cfg_idx_i == RegImageWidth) begin
        width_q <= cfg_data_i[CfgWidthW-1:0];
      end
      if (cfg_we_i && cfg_idx_i == RegImageHeight) begin
        height_q <= cfg_data_i[CfgHeightW-1:0];
      end
    end
  end

endmodule

@@ rtl/core/rbf_window.sv @@
// ----------------------------------------------------------------------------
// rbf_window
// 3x3 window registers and the per-channel sum of floor(pixel/9).
// ----------------------------------------------------------------------------
module rbf_window
  import rbf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic shift_i,
  input  pix_t up_i,
  input  pix_t lo_i,
  input  pix_t cur_i,
  output pix_t sum_o
);

  // Index row*3 + col; col 2 is the newest column
  pix_t win_q [9];
  pix_t win_d [9];
  logic [7:0] sum_r, sum_g, sum_b;

  // Shift one column left and load the new column
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r*3]     = win_q[r*3+1];
      win_d[r*3 + 1] = win_q[r*3+2];
    end
    win_d[2] = up_i;
    win_d[5] = lo_i;
    win_d[8] = cur_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
    end else if (shift_i) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= win_d[k];
      end
    end
  end

  // Sums over the shifted window; at most 9*28, fits 8 bits
  always_comb begin
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int k = 0; k < 9; k++) begin
      sum_r = sum_r + 8'(div9(win_d[k].r));
      sum_g = sum_g + 8'(div9(win_d[k].g));
      sum_b = sum_b + 8'(div9(win_d[k].b));
    end
  end

  assign sum_o = '{r: sum_r, g: sum_g, b: sum_b};

endmodule

@@ rtl/core/rgb_box_filter_3x3_unit.sv @@
// ----------------------------------------------------------------------------
// rgb_box_filter_3x3_unit
// 3x3 box filter over an RGB raster stream, valid-window output.
//
//   channel | signals                                   | role
//   --------+-------------------------------------------+-------------------
//   in      | in_valid_i/in_ready_o, red/green/blue_i   | pixel in
//   out     | out_valid_o/out_ready_i, out_*_o          | filtered pixel out
//   cfg     | cfg_we_i, cfg_idx_i, cfg_data_i           | register write
//
// One pixel per cycle while the output takes results; an accepted pixel's
// result passes the line store read register, then the output register.
// Reset clears counters, window and valid flags; line stores are not cleared.
// A stalled output holds one result while the input register still takes
// a pixel; pixels that produce no result pass regardless of the output.
// ----------------------------------------------------------------------------
module rgb_box_filter_3x3_unit
  import rbf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          red_i,
  input  logic [7:0]          green_i,
  input  logic [7:0]          blue_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_red_o,
  output logic [7:0]          out_green_o,
  output logic [7:0]          out_blue_o,
  output logic                last_of_frame_o
);

  pos_t pos;
  logic in_acc;
  logic s1_valid_q;
  pix_t s1_pix_q;
  pos_t s1_pos_q;
  logic s1_adv;
  logic out_load;
  pix_t up_rd, lo_rd, sum;
  logic out_valid_q;
  pix_t out_pix_q;
  logic out_last_q;

  assign in_acc = in_valid_i && in_ready_o;

  rbf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (in_acc),
    .pos_o      (pos)
  );

  // Input stage advances unless its result would overwrite a waiting one
  assign s1_adv     = s1_valid_q && (!s1_pos_q.emit || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign out_load   = s1_adv && s1_pos_q.emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q <= '{r: red_i, g: green_i, b: blue_i};
      s1_pos_q <= pos;
    end
  end

  // Line stores: read on accept, write back as the pixel leaves stage one
  rbf_line_store u_upper (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_pos_q.col),
    .wdata_i (lo_rd),
    .re_i    (in_acc),
    .raddr_i (pos.col),
    .rdata_o (up_rd)
  );

  rbf_line_store u_lower (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_pos_q.col),
    .wdata_i (s1_pix_q),
    .re_i    (in_acc),
    .raddr_i (pos.col),
    .rdata_o (lo_rd)
  );

  rbf_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s1_adv),
    .up_i    (up_rd),
    .lo_i    (lo_rd),
    .cur_i   (s1_pix_q),
    .sum_o   (sum)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pix_q  <= sum;
      out_last_q <= s1_pos_q.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_red_o       = out_pix_q.r;
  assign out_green_o     = out_pix_q.g;
  assign out_blue_o      = out_pix_q.b;
  assign last_of_frame_o = out_last_q;

  // A line store never reads the entry it writes in the same cycle
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && in_acc) |-> (s1_pos_q.col != pos.col))
    else $error("line store read and write hit the same column");

  // A stalled input stage keeps its pixel and position
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_pix_q) && $stable(s1_pos_q)))
    else $error("stalled input stage changed");

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !out_load)
    else $error("output register overwritten while stalled");

  // A register write restarts the frame
  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && (cfg_idx_i == RegImageWidth || cfg_idx_i == RegImageHeight))
    |=> (pos.col == '0 && !pos.emit))
    else $error("register write did not restart the frame");

endmodule
